[rtl/core/dawc_pkg.sv]
// Shared types and constants of the distinct anagram window counter.
// Depends on nothing; imported by the hash unit and the top level.
package dawc_pkg;

  // Hash arithmetic
  localparam int unsigned HASH_W       = 30;
  localparam logic [29:0] HASH_P       = 30'd1000000007;
  localparam logic [7:0]  BASE_A       = 8'd131;
  localparam logic [7:0]  BASE_B       = 8'd149;
  // floor(2^40 / HASH_P), used for the quotient estimate
  localparam logic [10:0] HASH_RECIP   = 11'd1099;
  localparam logic [6:0]  CODE_OFFSET  = 7'd97;

  // Letters and result layout
  localparam int unsigned LETTERS      = 26;
  localparam logic [4:0]  MAX_LETTER   = 5'd25;
  localparam int unsigned KEY_W        = 61;
  localparam int unsigned COUNT_W      = 13;

  // Request kinds carried on in_tuser
  localparam logic REQ_NEEDLE   = 1'b0;
  localparam logic REQ_HAYSTACK = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_NPA, ST_NPB, ST_HOLD, ST_HADD, ST_HMA, ST_HSA,
    ST_HMB, ST_HSB, ST_HKEY, ST_SRD, ST_SCMP, ST_INS, ST_RES
  } state_t;

  // Request into the modular multiply unit: (a * m + c) mod HASH_P
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [7:0]        m;
    logic [7:0]        c;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] res;
  } mm_rsp_t;

endpackage

[rtl/core/distinct_anagram_window_counter.sv]
// Top level of the distinct anagram window counter: sequencer, histograms,
// window and key memories. Depends on dawc_pkg and dawc_modmul.
//
// One item at a time. A needle letter runs two modular multiplies on the
// shared dawc_modmul unit, unless the needle is already full. A haystack
// letter runs two multiplies before a full window drops its oldest letter
// and four once it does; a matching window then scans the key memory
// through its single read port, one stored key at a time, with a read state
// and a compare state per key. Invalid letters and haystack letters before
// any needle go straight to the result. Any item can stall while the result
// register waits to drain.
// in_tready is high only while the sequencer is idle; the result register
// lets the next item start while a result waits. No clearing pass: keys fill
// the memory in order, so the distinct count marks which entries are written.
module distinct_anagram_window_counter #(
  parameter int unsigned MAX_NEEDLE = 1024,
  parameter int unsigned SET_SIZE   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] letter, [7:5] zero
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // [0] window_match, [61:1] window_key, [62] key_new,
                                  // [75:63] distinct_count, [76] set_full, [79:77] zero
);
  import dawc_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_NEEDLE + 1);
  localparam int unsigned PTR_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int unsigned CNT_W = $clog2(SET_SIZE + 1);
  localparam int unsigned IDX_W = $clog2(SET_SIZE);

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  nh_r [LETTERS];
  logic [LEN_W-1:0]  nh_nxt [LETTERS];
  logic [LEN_W-1:0]  wh_r [LETTERS];
  logic [LEN_W-1:0]  wh_nxt [LETTERS];
  logic [LEN_W-1:0]  nlen_r, nlen_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [PTR_W-1:0]  ring_r, ring_nxt;
  logic [4:0]        ndist_r, ndist_nxt;
  logic [4:0]        mism_r, mism_nxt;
  logic [HASH_W-1:0] ha_r, ha_nxt, hb_r, hb_nxt;
  logic [HASH_W-1:0] pwa_r, pwa_nxt, pwb_r, pwb_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic              wait_r, wait_nxt;

  // per-item registers
  logic              req_r, req_nxt;
  logic [4:0]        let_r, let_nxt;
  logic              drop_r, drop_nxt;
  logic              match_r, match_nxt, new_r, new_nxt, full_r, full_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [79:0]       out_data_r, out_data_nxt;

  // memories
  logic [4:0]        win_mem [MAX_NEEDLE];
  logic [4:0]        win_rd_r;
  logic [KEY_W-1:0]  key_mem [SET_SIZE];
  logic [KEY_W-1:0]  key_rd_r;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic [4:0]       in_letter;
  logic             accept;
  logic [4:0]       hsel;
  logic [LEN_W-1:0] hcur, hneed, hnew;
  logic             heq_b, heq_a;
  logic [LEN_W-1:0] ring_inc;
  logic [7:0]       old_code, new_code;

  dawc_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  function automatic logic [HASH_W-1:0] mod_sub(input logic [HASH_W-1:0] x,
                                                input logic [HASH_W-1:0] y);
    logic [HASH_W:0] d;
    d = {1'b0, x} - {1'b0, y};
    if (d[HASH_W]) d = d + {1'b0, HASH_P};
    return d[HASH_W-1:0];
  endfunction

  assign in_letter = in_tdata[4:0];
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign old_code  = 8'(win_rd_r) + 8'(CODE_OFFSET);
  assign new_code  = 8'(let_r) + 8'(CODE_OFFSET);
  assign ring_inc  = LEN_W'(ring_r) + LEN_W'(1);

  // histogram entry touched this cycle: oldest letter, then new letter
  assign hsel  = (state_r == ST_HOLD) ? win_rd_r : let_r;
  assign hcur  = wh_r[hsel];
  assign hneed = nh_r[hsel];
  always_comb begin
    if (state_r == ST_HADD) hnew = hcur + LEN_W'(1);
    else if (hcur != '0)    hnew = hcur - LEN_W'(1);
    else                    hnew = hcur;
  end
  assign heq_b = (hcur == hneed);
  assign heq_a = (hnew == hneed);

  // sequencer: next state and next values
  always_comb begin
    state_nxt     = state_r;
    nh_nxt        = nh_r;
    wh_nxt        = wh_r;
    nlen_nxt      = nlen_r;
    fill_nxt      = fill_r;
    ring_nxt      = ring_r;
    ndist_nxt     = ndist_r;
    mism_nxt      = mism_r;
    ha_nxt        = ha_r;
    hb_nxt        = hb_r;
    pwa_nxt       = pwa_r;
    pwb_nxt       = pwb_r;
    total_nxt     = total_r;
    scan_nxt      = scan_r;
    wait_nxt      = wait_r;
    req_nxt       = req_r;
    let_nxt       = let_r;
    drop_nxt      = drop_r;
    match_nxt     = match_r;
    new_nxt       = new_r;
    full_nxt      = full_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mm_req.start  = 1'b0;
    mm_req.a      = ha_r;
    mm_req.m      = BASE_A;
    mm_req.c      = 8'd0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          req_nxt   = in_tuser;
          let_nxt   = in_letter;
          drop_nxt  = (fill_r >= nlen_r);
          match_nxt = 1'b0;
          new_nxt   = 1'b0;
          full_nxt  = 1'b0;
          key_nxt   = '0;
          if (in_letter > MAX_LETTER) begin
            state_nxt = ST_RES;
          end else if (in_tuser == REQ_NEEDLE) begin
            for (int i = 0; i < LETTERS; i++) wh_nxt[i] = '0;
            fill_nxt = '0;
            ring_nxt = '0;
            ha_nxt   = '0;
            hb_nxt   = '0;
            if (nlen_r < LEN_W'(MAX_NEEDLE)) begin
              nh_nxt[in_letter] = nh_r[in_letter] + LEN_W'(1);
              nlen_nxt = nlen_r + LEN_W'(1);
              if (nh_r[in_letter] == '0) ndist_nxt = ndist_r + 5'd1;
              state_nxt = ST_NPA;
            end else begin
              state_nxt = ST_RES;
            end
            mism_nxt = ndist_nxt;
          end else if (nlen_r == '0) begin
            state_nxt = ST_RES;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end

      // needle: advance both base powers
      ST_NPA: begin
        mm_req.start = !wait_r;
        mm_req.a     = pwa_r;
        mm_req.m     = BASE_A;
        wait_nxt     = 1'b1;
        if (mm_rsp.done) begin
          pwa_nxt   = mm_rsp.res;
          wait_nxt  = 1'b0;
          state_nxt = ST_NPB;
        end
      end
      ST_NPB: begin
        mm_req.start = !wait_r;
        mm_req.a     = pwb_r;
        mm_req.m     = BASE_B;
        wait_nxt     = 1'b1;
        if (mm_rsp.done) begin
          pwb_nxt   = mm_rsp.res;
          wait_nxt  = 1'b0;
          state_nxt = ST_RES;
        end
      end

      // haystack: retire oldest letter once the window is full, else grow fill; advance ring
      ST_HOLD: begin
        if (drop_r) begin
          wh_nxt[win_rd_r] = hnew;
          if (heq_b && !heq_a) mism_nxt = mism_r + 5'd1;
          if (!heq_b && heq_a) mism_nxt = mism_r - 5'd1;
        end else begin
          fill_nxt = fill_r + LEN_W'(1);
        end
        ring_nxt  = (ring_inc >= nlen_r) ? '0 : PTR_W'(ring_inc);
        state_nxt = ST_HADD;
      end
      ST_HADD: begin
        wh_nxt[let_r] = hnew;
        if (heq_b && !heq_a) mism_nxt = mism_r + 5'd1;
        if (!heq_b && heq_a) mism_nxt = mism_r - 5'd1;
        state_nxt = ST_HMA;
      end

      // rolling hashes: shift in new code, subtract oldest term once the window is full
      ST_HMA: begin
        mm_req.start = !wait_r;
        mm_req.a     = ha_r;
        mm_req.m     = BASE_A;
        mm_req.c     = new_code;
        wait_nxt     = 1'b1;
        if (mm_rsp.done) begin
          ha_nxt    = mm_rsp.res;
          wait_nxt  = 1'b0;
          state_nxt = drop_r ? ST_HSA : ST_HMB;
        end
      end
      ST_HSA: begin
        mm_req.start = !wait_r;
        mm_req.a     = pwa_r;
        mm_req.m     = old_code;
        wait_nxt     = 1'b1;
        if (mm_rsp.done) begin
          ha_nxt    = mod_sub(ha_r, mm_rsp.res);
          wait_nxt  = 1'b0;
          state_nxt = ST_HMB;
        end
      end
      ST_HMB: begin
        mm_req.start = !wait_r;
        mm_req.a     = hb_r;
        mm_req.m     = BASE_B;
        mm_req.c     = new_code;
        wait_nxt     = 1'b1;
        if (mm_rsp.done) begin
          hb_nxt    = mm_rsp.res;
          wait_nxt  = 1'b0;
          state_nxt = drop_r ? ST_HSB : ST_HKEY;
        end
      end
      ST_HSB: begin
        mm_req.start = !wait_r;
        mm_req.a     = pwb_r;
        mm_req.m     = old_code;
        wait_nxt     = 1'b1;
        if (mm_rsp.done) begin
          hb_nxt    = mod_sub(hb_r, mm_rsp.res);
          wait_nxt  = 1'b0;
          state_nxt = ST_HKEY;
        end
      end

      // key formation and match decision
      ST_HKEY: begin
        state_nxt = ST_RES;
        if (fill_r >= nlen_r) begin
          key_nxt = {ha_r, 1'b0, hb_r};
          if (mism_r == 5'd0) begin
            match_nxt = 1'b1;
            scan_nxt  = '0;
            state_nxt = (total_r == '0) ? ST_INS : ST_SRD;
          end
        end
      end

      // linear scan of stored keys
      ST_SRD: begin
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        if (key_rd_r == key_r) begin
          state_nxt = ST_RES;
        end else if (scan_r + CNT_W'(1) == total_r) begin
          state_nxt = ST_INS;
        end else begin
          scan_nxt  = scan_r + CNT_W'(1);
          state_nxt = ST_SRD;
        end
      end
      ST_INS: begin
        if (total_r < CNT_W'(SET_SIZE)) begin
          total_nxt = total_r + CNT_W'(1);
          new_nxt   = 1'b1;
        end else begin
          full_nxt = 1'b1;
        end
        state_nxt = ST_RES;
      end

      // hand result to the output register
      ST_RES: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, full_r, COUNT_W'(total_r), new_r, key_r, match_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      for (int i = 0; i < LETTERS; i++) begin
        nh_r[i] <= '0;
        wh_r[i] <= '0;
      end
      nlen_r      <= '0;
      fill_r      <= '0;
      ring_r      <= '0;
      ndist_r     <= '0;
      mism_r      <= '0;
      ha_r        <= '0;
      hb_r        <= '0;
      pwa_r       <= HASH_W'(1);
      pwb_r       <= HASH_W'(1);
      total_r     <= '0;
      scan_r      <= '0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nh_r        <= nh_nxt;
      wh_r        <= wh_nxt;
      nlen_r      <= nlen_nxt;
      fill_r      <= fill_nxt;
      ring_r      <= ring_nxt;
      ndist_r     <= ndist_nxt;
      mism_r      <= mism_nxt;
      ha_r        <= ha_nxt;
      hb_r        <= hb_nxt;
      pwa_r       <= pwa_nxt;
      pwb_r       <= pwb_nxt;
      total_r     <= total_nxt;
      scan_r      <= scan_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    let_r      <= let_nxt;
    drop_r     <= drop_nxt;
    match_r    <= match_nxt;
    new_r      <= new_nxt;
    full_r     <= full_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  // window letter ring: read oldest on accept, overwrite it afterwards
  always_ff @(posedge clk) begin
    if (accept) win_rd_r <= win_mem[ring_r];
    if (state_r == ST_HOLD) win_mem[ring_r] <= let_r;
  end

  // key store: scan read, in-order insert
  always_ff @(posedge clk) begin
    if (state_r == ST_SRD) key_rd_r <= key_mem[scan_r[IDX_W-1:0]];
    if (state_r == ST_INS && total_r < CNT_W'(SET_SIZE)) begin
      key_mem[total_r[IDX_W-1:0]] <= key_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_mism_range: assert property (@(posedge clk) disable iff (!rst_n)
    mism_r <= 5'(LETTERS))
    else $error("histogram mismatch count out of range");

  a_fill_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= nlen_r)
    else $error("window fill exceeds needle length");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(SET_SIZE))
    else $error("distinct key count exceeds set size");

  a_mm_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == ST_NPA || state_r == ST_NPB || state_r == ST_HMA ||
                     state_r == ST_HSA || state_r == ST_HMB || state_r == ST_HSB))
    else $error("multiply result with no waiting step");

  a_new_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[62] && out_tdata[76]))
    else $error("key reported both new and dropped");

endmodule

[rtl/core/dawc_modmul.sv]
// Shared modular multiply-add unit: (a * m + c) mod HASH_P.
// Depends on dawc_pkg for the request and response types.
module dawc_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  dawc_pkg::mm_req_t req,
  output dawc_pkg::mm_rsp_t rsp
);
  import dawc_pkg::*;

  logic [38:0]       v_r;
  logic [9:0]        q_r;
  logic [30:0]       rem_r;
  logic [HASH_W-1:0] res_r;
  logic [1:0]        step_r;
  logic              busy_r;
  logic              done_r;

  logic [29:0] qprod;
  logic [39:0] qp;

  // quotient estimate, at most one short of the true quotient
  assign qprod = 30'(v_r[38:20]) * 30'(HASH_RECIP);
  assign qp    = 40'(q_r) * 40'(HASH_P);

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          step_r <= 2'd1;
        end
      end else begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: product, quotient, remainder, final correction
  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      v_r <= 39'(38'(req.a) * 38'(req.m)) + 39'(req.c);
    end
    if (busy_r && step_r == 2'd1) q_r <= qprod[29:20];
    if (busy_r && step_r == 2'd2) rem_r <= 31'(40'(v_r) - qp);
    if (busy_r && step_r == 2'd3) begin
      res_r <= (rem_r >= 31'(HASH_P)) ? HASH_W'(rem_r - 31'(HASH_P)) : rem_r[HASH_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
